/* rtl/counting_semaphore_bank_macros.svh */
// Assertion macros shared by the counting semaphore bank RTL.
`ifndef COUNTING_SEMAPHORE_BANK_MACROS_SVH
`define COUNTING_SEMAPHORE_BANK_MACROS_SVH

// Checked only outside reset.
`define CSB_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CSB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/csb_pkg.sv */
// Shared types and constants of the counting semaphore bank.
package csb_pkg;

  localparam int SEM_SLOTS_DEF  = 256;
  localparam int COUNT_BITS_DEF = 16;

  localparam int ID_W   = 8;
  localparam int INIT_W = 16;
  localparam int MAX_W  = 15;
  localparam int OUT_W  = 16;
  localparam int ID_SPAN = 256;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_WAIT   = 2'd1,
    KIND_SIGNAL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_BLOCK  = 2'd2
  } status_t;

  // Outcome of one request as decided by the update logic.
  typedef struct packed {
    status_t            status;
    logic signed [15:0] count_after;
    logic               wake_one;
    logic               write;
    logic               set_valid;
  } csb_result_t;

endpackage

/* rtl/csb_ram.sv */
// Entry memory holding count and ceiling, with write-to-read forwarding.
module csb_ram
  import csb_pkg::*;
#(
  parameter int DEPTH  = SEM_SLOTS_DEF,
  parameter int WORD_W = COUNT_BITS_DEF + MAX_W,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_word
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q;
  logic [WORD_W-1:0] fwd_word;
  logic              fwd_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_word;
    end
    mem_q <= mem[rd_addr];
  end

  // A write to the entry being read in the same cycle wins over the old data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= we && (wr_addr == rd_addr);
    end
    fwd_word <= wr_word;
  end

  assign rd_data = fwd_hit ? fwd_word : mem_q;

endmodule

/* rtl/csb_update.sv */
// Decision and arithmetic for one semaphore request.
module csb_update
  import csb_pkg::*;
#(
  parameter int SEM_SLOTS  = SEM_SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int WORD_W = COUNT_BITS + MAX_W
) (
  input  logic [1:0]               kind,
  input  logic [ID_W-1:0]          sem_id,
  input  logic signed [INIT_W-1:0] start_count,
  input  logic [MAX_W-1:0]         ceiling_in,
  input  logic                     slot_valid,
  input  logic [WORD_W-1:0]        entry,
  output csb_result_t              result,
  output logic [WORD_W-1:0]        new_entry
);

  localparam int CMP_W = ((COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W) + 1;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};

  logic signed [COUNT_BITS-1:0] cnt;
  logic [MAX_W-1:0]             ceil;
  logic signed [COUNT_BITS-1:0] init;
  logic signed [COUNT_BITS-1:0] cnt_dec;
  logic signed [COUNT_BITS-1:0] cnt_inc;
  logic signed [CMP_W-1:0]      cnt_x;
  logic signed [CMP_W-1:0]      ceil_x;
  logic                         id_ok;
  logic                         can_inc;

  assign cnt     = entry[COUNT_BITS-1:0];
  assign ceil    = entry[WORD_W-1:COUNT_BITS];
  assign init    = COUNT_BITS'(start_count);
  assign cnt_dec = cnt - COUNT_BITS'(1);
  assign cnt_inc = cnt + COUNT_BITS'(1);
  assign cnt_x   = CMP_W'(cnt);
  assign ceil_x  = CMP_W'({1'b0, ceil});
  assign id_ok   = 32'(sem_id) < 32'(SEM_SLOTS);
  assign can_inc = (cnt_x < ceil_x) && (cnt != CNT_MAX);

  always_comb begin
    result.status      = ST_REJECT;
    result.count_after = '0;
    result.wake_one    = 1'b0;
    result.write       = 1'b0;
    result.set_valid   = 1'b0;
    new_entry          = {ceil, cnt};
    if (id_ok) begin
      unique case (kind)
        KIND_CREATE: begin
          if (!slot_valid) begin
            result.status      = ST_DONE;
            result.count_after = OUT_W'(init);
            result.write       = 1'b1;
            result.set_valid   = 1'b1;
            new_entry          = {ceiling_in, init};
          end
        end
        KIND_WAIT: begin
          if (slot_valid) begin
            if (!cnt[COUNT_BITS-1] && (cnt != '0)) begin
              result.status      = ST_DONE;
              result.count_after = OUT_W'(cnt_dec);
              result.write       = 1'b1;
              new_entry          = {ceil, cnt_dec};
            end else begin
              result.status      = ST_BLOCK;
              result.count_after = OUT_W'(cnt);
            end
          end
        end
        KIND_SIGNAL: begin
          if (slot_valid) begin
            result.status = ST_DONE;
            if (can_inc) begin
              result.count_after = OUT_W'(cnt_inc);
              result.wake_one    = 1'b1;
              result.write       = 1'b1;
              new_entry          = {ceil, cnt_inc};
            end else begin
              result.count_after = OUT_W'(cnt);
            end
          end
        end
        default: begin
          result.status = ST_REJECT;
        end
      endcase
    end
  end

endmodule

/* rtl/counting_semaphore_bank.sv */
// Top level of the counting semaphore bank: request pipeline, valid bits and result register.
//
// A bank of counting semaphores addressed by an 8-bit id. Each request word on the
// slave stream carries its kind in s_tuser (create, wait or signal) and the id,
// starting count and ceiling in s_tdata. Every request yields exactly one result
// word on the master stream: a status in m_tuser and the count after the request
// plus a wake-one flag in m_tdata. Wait on a count that is not positive answers
// would-block and changes nothing; signal stops at the ceiling.
// Count and ceiling of each slot live in a one-port-read, one-port-write memory
// with a registered read; slot valid bits are flip-flops. An accepted request is
// held in the request register while its entry is read; it is decided, written
// back and loaded into the result register when it advances to the output.
// Throughput is one word per cycle when not stalled, set by the memory read-modify-write
// loop; a write that lands on the entry the next request reads is forwarded.
// Reset clears all valid bits and empties the pipeline at once; no clearing pass.
// When the receiver stalls, the result register holds its word, the request in
// flight waits behind it, and s_tready drops until the result word is taken.
module counting_semaphore_bank
  import csb_pkg::*;
#(
  parameter int SEM_SLOTS  = SEM_SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // sem_id[7:0], start_count[23:8], ceiling_in[38:24], zero
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // count_after[15:0], wake_one[16], zero
  output logic [1:0]  m_tuser    // status[1:0]
);

  // Only ids below both the slot count and the id range can ever reach storage.
  localparam int RAM_DEPTH = (SEM_SLOTS < ID_SPAN) ? SEM_SLOTS : ID_SPAN;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int WORD_W    = COUNT_BITS + MAX_W;

  // Request register: the word whose entry read is in flight.
  logic                     r_valid;
  logic [1:0]               r_kind;
  logic [ID_W-1:0]          r_id;
  logic signed [INIT_W-1:0] r_init;
  logic [MAX_W-1:0]         r_max;
  logic [ADDR_W-1:0]        r_addr;

  logic [RAM_DEPTH-1:0]     slot_valid;
  logic [ADDR_W-1:0]        rd_addr;
  logic [WORD_W-1:0]        rd_data;
  logic [WORD_W-1:0]        new_entry;
  csb_result_t              upd;

  // Result register.
  status_t                  out_status;
  logic signed [OUT_W-1:0]  out_count;
  logic                     out_wake;

  logic                     accept;
  logic                     advance;

  // The request moves on when the result register is free or being emptied.
  assign advance  = r_valid && (!m_tvalid || m_tready);
  assign s_tready = !r_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign r_addr   = r_id[ADDR_W-1:0];

  // A held request keeps reading its own entry so the data stays current.
  assign rd_addr = accept ? s_tdata[ADDR_W-1:0] : r_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s_tready) begin
      r_valid <= s_tvalid;
    end
    if (accept) begin
      r_kind <= s_tuser;
      r_id   <= s_tdata[7:0];
      r_init <= s_tdata[23:8];
      r_max  <= s_tdata[38:24];
    end
  end

  csb_ram #(
    .DEPTH  (RAM_DEPTH),
    .WORD_W (WORD_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (advance && upd.write),
    .wr_addr (r_addr),
    .wr_word (new_entry)
  );

  csb_update #(
    .SEM_SLOTS  (SEM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .kind        (r_kind),
    .sem_id      (r_id),
    .start_count (r_init),
    .ceiling_in  (r_max),
    .slot_valid  (slot_valid[r_addr]),
    .entry       (rd_data),
    .result      (upd),
    .new_entry   (new_entry)
  );

  // Valid bits are written in the same cycle as the decision, so the next
  // request already sees a slot that was just created.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (advance && upd.set_valid) begin
      slot_valid[r_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      out_status <= upd.status;
      out_count  <= upd.count_after;
      out_wake   <= upd.wake_one;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {7'b0, out_wake, out_count};

`include "counting_semaphore_bank_macros.svh"

  `CSB_ASSERT_RUN(a_wake_only_done, m_tvalid && out_wake |-> out_status == ST_DONE, "wake not done")
  `CSB_ASSERT_RUN(a_reject_zero, m_tvalid && (out_status == ST_REJECT) |-> out_count == '0, "reject count")
  `CSB_ASSERT_RUN(a_create_sets_valid, advance && upd.set_valid |=> slot_valid[$past(r_addr)], "no valid")
  `CSB_ASSERT_RUN(a_stall_holds, r_valid && !advance |=> r_valid && $stable(r_id) && $stable(r_kind), "stall")
  `CSB_ASSERT_ALWAYS(a_reset_empty, rst |=> !r_valid && !m_tvalid && (slot_valid == '0), "reset state")

endmodule

/* tb/sv/tb_counting_semaphore_bank.sv */
// Self-checking testbench for the counting semaphore bank: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_counting_semaphore_bank;
  import csb_pkg::*;

  // kind 3 is not a legal request; the block must reject it.
  localparam logic [1:0] KIND_BAD = 2'd3;

  // Largest value the count can hold; a signal never moves past it.
  localparam int COUNT_TOP = 2 ** (COUNT_BITS_DEF - 1) - 1;

  localparam int RANDOM_WORDS   = 600;
  localparam int CALM_TAIL      = 80;    // last random words, sent with no idling at all
  localparam int LONG_HOLD      = 200;   // receiver hold-off that backs the block up
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES   = 8;     // margin after the last expected result
  localparam int MAX_PRINTED    = 30;

  // Result word as the bank should produce it.
  typedef struct packed {
    status_t            status;
    logic signed [15:0] count;
    logic               wake;
  } sem_outcome_t;

  // One row of the directed table. Rows with known set carry a typed-in result;
  // all other rows are checked against the predictor.
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         id;
    logic signed [15:0] init;
    logic [14:0]        ceiling;
    logic               known;
    sem_outcome_t       result;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // Predictor state: our own copy of the semaphore table.
  logic               sem_live    [ID_SPAN];
  logic signed [15:0] sem_count   [ID_SPAN];
  logic [14:0]        sem_ceiling [ID_SPAN];

  sem_outcome_t pending_results [$];
  probe_row_t   probe_table [$];

  int error_count   = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int block_seen    = 0;
  int wake_seen     = 0;
  int reject_seen   = 0;
  int quiet_cycles  = 0;

  // Idling controls shared between the stimulus and the receiver.
  bit send_gaps     = 1'b0;
  bit result_stalls = 1'b0;
  bit hold_results  = 1'b0;

  counting_semaphore_bank u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one line per mismatch (up to a cap) and counts every one of them.
  task automatic report_mismatch(input string what, input int got, input int want);
    begin
      error_count++;
      if (error_count <= MAX_PRINTED)
        $display("%0t ns: MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // Applies one request to the predictor table and returns the word the bank owes.
  // Anything that is not a create, wait or signal on a proper slot is rejected
  // with a zero count and leaves the table alone.
  function automatic sem_outcome_t resolve_request(input logic [1:0] kind,
                                                   input logic [7:0] id,
                                                   input logic signed [15:0] init,
                                                   input logic [14:0] ceiling);
    sem_outcome_t res;
    int           cur;
    res.status = ST_REJECT;
    res.count  = 16'sd0;
    res.wake   = 1'b0;
    if (kind == KIND_CREATE) begin
      if (!sem_live[id]) begin
        sem_live[id]    = 1'b1;
        sem_count[id]   = init;
        sem_ceiling[id] = ceiling;
        res.status      = ST_DONE;
        res.count       = init;
      end
    end else if ((kind == KIND_WAIT || kind == KIND_SIGNAL) && sem_live[id]) begin
      cur        = int'(sem_count[id]);
      res.status = ST_DONE;
      if (kind == KIND_WAIT) begin
        // A count of zero or below would block; nothing changes.
        if (cur <= 0) res.status = ST_BLOCK;
        else sem_count[id] = sem_count[id] - 16'sd1;
      end else if (cur < int'(sem_ceiling[id]) && cur < COUNT_TOP) begin
        // Signed compare: a negative count is below any ceiling.
        sem_count[id] = sem_count[id] + 16'sd1;
        res.wake      = 1'b1;
      end
      res.count = sem_count[id];
    end
    return res;
  endfunction

  task automatic add_probe(input logic [1:0] kind, input logic [7:0] id,
                           input logic signed [15:0] init, input logic [14:0] ceiling,
                           input logic known, input status_t status,
                           input logic signed [15:0] count, input logic wake);
    probe_row_t row;
    begin
      row.kind           = kind;
      row.id             = id;
      row.init           = init;
      row.ceiling        = ceiling;
      row.known          = known;
      row.result.status  = status;
      row.result.count   = count;
      row.result.wake    = wake;
      probe_table.push_back(row);
    end
  endtask

  // Offers one request word and waits for the handshake. The expected result is
  // queued at the edge where the word is taken, so the queue order matches the
  // order in which the bank sees requests.
  task automatic send_request(input logic [1:0] kind, input logic [7:0] id,
                              input logic signed [15:0] init, input logic [14:0] ceiling,
                              input logic known, input sem_outcome_t typed);
    sem_outcome_t predicted;
    begin
      if (send_gaps && $urandom_range(0, 4) == 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
      @(negedge clk);
      s_tvalid <= 1'b1;
      s_tuser  <= kind;
      s_tdata  <= {1'b0, ceiling, init, id};
      do @(posedge clk); while (!s_tready);
      predicted = resolve_request(kind, id, init, ceiling);
      pending_results.push_back(known ? typed : predicted);
      words_sent++;
    end
  endtask

  // Random request. Most traffic lands on a small group of slots so that creates
  // are followed by long runs of waits and signals that cross zero and hit the
  // ceiling; the rest spreads over the whole id space with full-width values.
  task automatic send_random_request;
    logic [1:0]         kind;
    logic [7:0]         id;
    logic signed [15:0] init;
    logic [14:0]        ceiling;
    sem_outcome_t       unused;
    int                 pick;
    begin
      pick = $urandom_range(0, 99);
      if (pick < 12)      kind = KIND_CREATE;
      else if (pick < 52) kind = KIND_WAIT;
      else if (pick < 94) kind = KIND_SIGNAL;
      else                kind = KIND_BAD;
      id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 23)) : 8'($urandom);
      if ($urandom_range(0, 4) < 3) init = 16'($urandom_range(0, 8)) - 16'sd2;
      else init = 16'($urandom);
      if ($urandom_range(0, 4) < 3) ceiling = 15'($urandom_range(0, 6));
      else ceiling = 15'($urandom);
      unused = '0;
      send_request(kind, id, init, ceiling, 1'b0, unused);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request that lets the
  // block fill up and push back on its input.
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (result_stalls && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker: every taken word is matched against the oldest expectation.
  always @(posedge clk) begin
    sem_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending, status", m_tuser, -1);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (m_tuser != want.status)
          report_mismatch("status", m_tuser, want.status);
        if (m_tdata[15:0] != want.count)
          report_mismatch("count_after", $signed(m_tdata[15:0]), want.count);
        if (m_tdata[16] != want.wake)
          report_mismatch("wake_one", m_tdata[16], want.wake);
        if (want.status == ST_BLOCK)  block_seen++;
        if (want.status == ST_REJECT) reject_seen++;
        if (want.wake)                wake_seen++;
      end
    end
  end

  // Watchdog: the longest correct silence is the long hold-off, far below the limit.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_counting_semaphore_bank: done, errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < ID_SPAN; i++) sem_live[i] = 1'b0;

    // Requests on empty slots and an unknown kind are all rejected.
    add_probe(KIND_WAIT,   8'd0,   16'sd0,      15'd0,     1'b1, ST_REJECT, 16'sd0, 1'b0);
    add_probe(KIND_SIGNAL, 8'd255, 16'sd0,      15'd0,     1'b1, ST_REJECT, 16'sd0, 1'b0);
    add_probe(KIND_BAD,    8'd5,   16'sd0,      15'd0,     1'b1, ST_REJECT, 16'sd0, 1'b0);
    // Slot with ceiling zero: a second create is rejected, wait blocks, signal sits at the ceiling.
    add_probe(KIND_CREATE, 8'd0,   16'sd0,      15'd0,     1'b1, ST_DONE,   16'sd0, 1'b0);
    add_probe(KIND_CREATE, 8'd0,   16'sd7,      15'd9,     1'b1, ST_REJECT, 16'sd0, 1'b0);
    add_probe(KIND_WAIT,   8'd0,   16'sd0,      15'd0,     1'b1, ST_BLOCK,  16'sd0, 1'b0);
    add_probe(KIND_SIGNAL, 8'd0,   16'sd0,      15'd0,     1'b1, ST_DONE,   16'sd0, 1'b0);
    // Largest count and ceiling: the ceiling and the count width both stop the signal.
    add_probe(KIND_CREATE, 8'd255, 16'sd32767,  15'h7FFF,  1'b1, ST_DONE, 16'sd32767, 1'b0);
    add_probe(KIND_SIGNAL, 8'd255, 16'sd0,      15'd0,     1'b1, ST_DONE, 16'sd32767, 1'b0);
    add_probe(KIND_WAIT,   8'd255, 16'sd0,      15'd0,     1'b1, ST_DONE, 16'sd32766, 1'b0);
    add_probe(KIND_SIGNAL, 8'd255, 16'sd0,      15'd0,     1'b1, ST_DONE, 16'sd32767, 1'b1);
    // Most negative count: wait blocks, signal still wakes since it is below the ceiling.
    add_probe(KIND_CREATE, 8'd1,   16'sh8000,   15'h7FFF,  1'b1, ST_DONE,   16'sh8000, 1'b0);
    add_probe(KIND_WAIT,   8'd1,   16'sd0,      15'd0,     1'b1, ST_BLOCK,  16'sh8000, 1'b0);
    add_probe(KIND_SIGNAL, 8'd1,   16'sd0,      15'd0,     1'b1, ST_DONE,   16'sh8001, 1'b1);
    // Small slot walked down to zero and up to its ceiling, back to back.
    add_probe(KIND_CREATE, 8'd2,   16'sd1,      15'd2,     1'b0, ST_DONE, 16'sd0, 1'b0);
    add_probe(KIND_WAIT,   8'd2,   16'sd0,      15'd0,     1'b0, ST_DONE, 16'sd0, 1'b0);
    add_probe(KIND_WAIT,   8'd2,   16'sd0,      15'd0,     1'b0, ST_DONE, 16'sd0, 1'b0);
    add_probe(KIND_SIGNAL, 8'd2,   16'sd0,      15'd0,     1'b0, ST_DONE, 16'sd0, 1'b0);
    add_probe(KIND_SIGNAL, 8'd2,   16'sd0,      15'd0,     1'b0, ST_DONE, 16'sd0, 1'b0);
    add_probe(KIND_SIGNAL, 8'd2,   16'sd0,      15'd0,     1'b0, ST_DONE, 16'sd0, 1'b0);
    // Starting count above the ceiling: signal leaves it alone.
    add_probe(KIND_CREATE, 8'd3,   16'sd5,      15'd3,     1'b0, ST_DONE, 16'sd0, 1'b0);
    add_probe(KIND_SIGNAL, 8'd3,   16'sd0,      15'd0,     1'b0, ST_DONE, 16'sd0, 1'b0);
    // Alternating bit patterns, and an unknown kind with every data bit set.
    add_probe(KIND_CREATE, 8'hAA,  16'sh5555,   15'h2AAA,  1'b0, ST_DONE, 16'sd0, 1'b0);
    add_probe(KIND_WAIT,   8'hAA,  16'shAAAA,   15'h5555,  1'b0, ST_DONE, 16'sd0, 1'b0);
    add_probe(KIND_BAD,    8'hFF,  16'shFFFF,   15'h7FFF,  1'b1, ST_REJECT, 16'sd0, 1'b0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part, sent back to back with the receiver always ready.
    foreach (probe_table[i])
      send_request(probe_table[i].kind, probe_table[i].id, probe_table[i].init,
                   probe_table[i].ceiling, probe_table[i].known, probe_table[i].result);

    // Random part: idling on each side switches on and off in stretches, one long
    // receiver hold-off lands early on, and the tail runs at full rate.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) begin
        send_gaps     = ($urandom_range(0, 3) != 0);
        result_stalls = ($urandom_range(0, 3) != 0);
      end
      if (i >= RANDOM_WORDS - CALM_TAIL) begin
        send_gaps     = 1'b0;
        result_stalls = 1'b0;
      end
      if (i == 150) hold_results = 1'b1;
      send_random_request();
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    $display("Sent %0d request words (%0d from the directed table), checked %0d results.",
             words_sent, probe_table.size(), words_checked);
    $display("Seen: %0d would-block, %0d wake-one, %0d rejected; %0d mismatches.",
             block_seen, wake_seen, reject_seen, error_count);
    if (error_count == 0) begin
      $display("tb_counting_semaphore_bank: done, clean");
    end else begin
      $display("tb_counting_semaphore_bank: done, errors");
    end
    $finish;
  end

endmodule
